// File: rtl/core/mprc_pkg.sv
// ----------------------------------------------------------------------------
// mprc_pkg
// Types and register codes shared by the median prediction residual codec.
// ----------------------------------------------------------------------------
package mprc_pkg;

	localparam int PIX_W   = 8;
	localparam int VAL_W   = 9;
	localparam int PW_W    = 13;
	localparam int PH_W    = 16;
	localparam int CFG_I_W = 2;
	localparam int CFG_D_W = 16;

	typedef enum logic [CFG_I_W-1:0] {
		REG_PLANE_WIDTH  = 2'd0,
		REG_PLANE_HEIGHT = 2'd1,
		REG_DECODE_MODE  = 2'd2
	} cfg_reg_t;

	// Position of one pixel within the plane.
	typedef struct packed {
		logic first_col;
		logic first_row;
		logic last;
	} pos_flags_t;

endpackage

// File: rtl/core/med_prediction_residual_codec.sv
// ----------------------------------------------------------------------------
// med_prediction_residual_codec
// Raster-order median predictor for one image plane, encode or decode.
// ----------------------------------------------------------------------------
// Pixels (encode) or residuals (decode) enter on the in_valid/in_ready channel
// in raster order, one transfer per pixel. Each input transfer gives exactly
// one output transfer on out_valid/out_ready carrying the residual or the
// reconstructed pixel, with end_of_plane high on the last pixel of the plane.
// The configuration channel writes plane_width (index 0), plane_height
// (index 1) and decode_mode (index 2); any write restarts the plane. It is
// always ready; the user must write it only while the block is idle, and
// the block itself does not enforce this. The input is registered in the
// prediction stage, the result in the output register. One pixel is taken
// every cycle unless the output stalls: the row buffer is read when a pixel
// is taken and written as it leaves the prediction stage, with a bypass when
// both meet. When the receiver stalls, the output register holds its result
// and the prediction stage keeps one more pixel, after which in_ready falls.
// Reset clears the position, the neighbour registers and the configuration
// to width 1, height 1, encode. The row buffer needs no clearing.
// ----------------------------------------------------------------------------
module med_prediction_residual_codec #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mprc_pkg::CFG_I_W-1:0]      cfg_index,
	input  logic [mprc_pkg::CFG_D_W-1:0]      cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [mprc_pkg::VAL_W-1:0] sample_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [mprc_pkg::VAL_W-1:0] result_value,
	output logic                              end_of_plane
);

	import mprc_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	logic                    accept;
	logic                    advance;
	logic                    cfg_we;
	logic [CW-1:0]           col;
	pos_flags_t              flags;
	logic                    decode_mode;

	logic                    valid_s1;
	logic signed [VAL_W-1:0] sample_s1;
	logic [CW-1:0]           col_s1;
	pos_flags_t              flags_s1;
	logic                    byp_s1;
	logic [PIX_W-1:0]        byp_data_s1;

	logic [PIX_W-1:0]        left_q;
	logic [PIX_W-1:0]        upper_left_q;
	logic [PIX_W-1:0]        row_data;
	logic [PIX_W-1:0]        top_raw;
	logic [PIX_W-1:0]        top;
	logic [PIX_W-1:0]        pixel;
	logic signed [VAL_W-1:0] result;

	logic                    out_valid_q;
	logic signed [VAL_W-1:0] result_q;
	logic                    end_q;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && (cfg_index <= REG_DECODE_MODE);
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign accept    = in_valid && in_ready;

	mprc_scan #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.step       (accept),
		.col        (col),
		.flags      (flags),
		.decode_mode(decode_mode)
	);

	mprc_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_row_ram (
		.clk    (clk),
		.wr_en  (advance),
		.wr_addr(col_s1),
		.wr_data(pixel),
		.rd_en  (accept),
		.rd_addr(col),
		.rd_data(row_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1   <= sample_value;
			col_s1      <= col;
			flags_s1    <= flags;
			byp_s1      <= advance && (col_s1 == col);
			byp_data_s1 <= pixel;
		end
	end

	assign top_raw = byp_s1 ? byp_data_s1 : row_data;

	mprc_predict u_predict (
		.top_raw       (top_raw),
		.left_raw      (left_q),
		.upper_left_raw(upper_left_q),
		.flags         (flags_s1),
		.decode_mode   (decode_mode),
		.sample        (sample_s1),
		.top           (top),
		.pixel         (pixel),
		.result        (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q       <= '0;
			upper_left_q <= '0;
		end else if (cfg_we) begin
			left_q       <= '0;
			upper_left_q <= '0;
		end else if (advance) begin
			left_q       <= pixel;
			upper_left_q <= top;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
			end_q    <= flags_s1.last;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_q;
	assign end_of_plane = end_q;

endmodule

// File: rtl/core/mprc_ram.sv
// ----------------------------------------------------------------------------
// mprc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mprc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/core/mprc_scan.sv
// ----------------------------------------------------------------------------
// mprc_scan
// Configuration registers and the raster position of the next pixel.
// ----------------------------------------------------------------------------
module mprc_scan #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mprc_pkg::CFG_I_W-1:0]  cfg_index,
	input  logic [mprc_pkg::CFG_D_W-1:0]  cfg_data,
	input  logic                          step,
	output logic [$clog2(MAX_WIDTH)-1:0]  col,
	output mprc_pkg::pos_flags_t          flags,
	output logic                          decode_mode
);

	import mprc_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	logic [PW_W-1:0] width_q;
	logic [PH_W-1:0] height_q;
	logic            mode_q;
	logic [CW-1:0]   x_q;
	logic [PH_W-1:0] y_q;
	logic [PW_W-1:0] w_eff;
	logic [PH_W-1:0] h_eff;
	logic [CW-1:0]   x_cur;
	logic [PH_W-1:0] y_cur;
	logic            row_end;
	logic            plane_end;
	logic            cfg_hit;

	always_comb begin
		if (width_q == '0) begin
			w_eff = PW_W'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_eff = PW_W'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		h_eff = (height_q == '0) ? PH_W'(1) : height_q;
		x_cur = (32'(x_q) >= 32'(w_eff)) ? '0 : x_q;
		y_cur = (32'(y_q) >= 32'(h_eff)) ? '0 : y_q;
		row_end   = (32'(x_cur) + 32'd1) >= 32'(w_eff);
		plane_end = row_end && ((32'(y_cur) + 32'd1) >= 32'(h_eff));
	end

	always_comb begin
		unique case (cfg_reg_t'(cfg_index))
			REG_PLANE_WIDTH,
			REG_PLANE_HEIGHT,
			REG_DECODE_MODE: cfg_hit = cfg_we;
			default:         cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= PW_W'(1);
			height_q <= PH_W'(1);
			mode_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PLANE_WIDTH:  width_q  <= cfg_data[PW_W-1:0];
				REG_PLANE_HEIGHT: height_q <= cfg_data[PH_W-1:0];
				REG_DECODE_MODE:  mode_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
		end else if (cfg_hit) begin
			x_q <= '0;
			y_q <= '0;
		end else if (step) begin
			if (row_end) begin
				x_q <= '0;
				y_q <= plane_end ? '0 : y_cur + PH_W'(1);
			end else begin
				x_q <= x_cur + CW'(1);
				y_q <= y_cur;
			end
		end
	end

	assign col             = x_cur;
	assign flags.first_col = (x_cur == '0);
	assign flags.first_row = (y_cur == '0);
	assign flags.last      = plane_end;
	assign decode_mode     = mode_q;

endmodule

// File: rtl/core/mprc_predict.sv
// ----------------------------------------------------------------------------
// mprc_predict
// Median edge predictor with the encode and decode arithmetic.
// ----------------------------------------------------------------------------
module mprc_predict (
	input  logic [mprc_pkg::PIX_W-1:0]        top_raw,
	input  logic [mprc_pkg::PIX_W-1:0]        left_raw,
	input  logic [mprc_pkg::PIX_W-1:0]        upper_left_raw,
	input  mprc_pkg::pos_flags_t              flags,
	input  logic                              decode_mode,
	input  logic signed [mprc_pkg::VAL_W-1:0] sample,
	output logic [mprc_pkg::PIX_W-1:0]        top,
	output logic [mprc_pkg::PIX_W-1:0]        pixel,
	output logic signed [mprc_pkg::VAL_W-1:0] result
);

	import mprc_pkg::*;

	logic [PIX_W-1:0]          left;
	logic [PIX_W-1:0]          topleft;
	logic [PIX_W-1:0]          lo;
	logic [PIX_W-1:0]          hi;
	logic signed [PIX_W+1:0]   grad;
	logic [PIX_W-1:0]          pred;
	logic signed [VAL_W+1:0]   dec_sum;
	logic signed [VAL_W-1:0]   enc_res;

	always_comb begin
		top     = flags.first_row ? '0 : top_raw;
		left    = flags.first_col ? '0 : left_raw;
		topleft = (flags.first_col || flags.first_row) ? '0 : upper_left_raw;
		lo      = (top < left) ? top : left;
		hi      = (top < left) ? left : top;
		grad    = $signed({2'b00, top}) + $signed({2'b00, left})
			- $signed({2'b00, topleft});
		if (grad < $signed({2'b00, lo})) begin
			pred = lo;
		end else if (grad > $signed({2'b00, hi})) begin
			pred = hi;
		end else begin
			pred = grad[PIX_W-1:0];
		end

		dec_sum = {{2{sample[VAL_W-1]}}, sample} + $signed({3'b000, pred});

		if (decode_mode) begin
			if (dec_sum < 0) begin
				pixel = '0;
			end else if (dec_sum > $signed(11'd255)) begin
				pixel = '1;
			end else begin
				pixel = dec_sum[PIX_W-1:0];
			end
		end else begin
			pixel = sample[VAL_W-1] ? '0 : sample[PIX_W-1:0];
		end

		enc_res = $signed({1'b0, pixel}) - $signed({1'b0, pred});
		result  = decode_mode ? $signed({1'b0, pixel}) : enc_res;
	end

endmodule

// File: verif/med_prediction_residual_codec_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// med_prediction_residual_codec_tb
// Self-checking bench for the median prediction residual codec.
// ----------------------------------------------------------------------------
// A short table of directed transfers covers the field extremes, zero and
// oversized plane sizes, negative pixels and saturation in both directions.
// Random planes follow, in encode and decode, with random sizes and random
// stalls on both channels. Every output transfer is compared with the
// table's expected value where the table gives one, else with a behavioural
// predictor of the codec that tracks its own row buffer, neighbours and position.
// ----------------------------------------------------------------------------
module med_prediction_residual_codec_tb;

	import mprc_pkg::*;

	localparam int PLANE_MAX_W = 4096;
	localparam int RAND_ITEMS_PER_PHASE = 330;
	localparam int WIDE_PLANE_W = 160;

	typedef struct {
		logic signed [VAL_W-1:0] value;
		logic                    eop;
	} coded_pixel_t;

	typedef enum logic [1:0] {
		STIM_WRITE,
		STIM_PIXEL,
		STIM_PIXEL_KNOWN
	} stim_kind_t;

	typedef struct {
		stim_kind_t              kind;
		cfg_reg_t                idx;
		logic [CFG_D_W-1:0]      data;
		logic signed [VAL_W-1:0] sample;
		logic signed [VAL_W-1:0] want_value;
		logic                    want_eop;
	} stim_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_valid;
	logic                    cfg_ready;
	cfg_reg_t                cfg_index;
	logic [CFG_D_W-1:0]      cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	logic signed [VAL_W-1:0] sample_value;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [VAL_W-1:0] result_value;
	logic                    end_of_plane;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatch_count = 0;

	coded_pixel_t coded_q[$];

	logic [PW_W-1:0]  plane_w_cfg = PW_W'(1);
	logic [PH_W-1:0]  plane_h_cfg = PH_W'(1);
	logic             decode_cfg = 1'b0;
	logic [PIX_W-1:0] prev_row [PLANE_MAX_W];
	logic [PIX_W-1:0] left_pix = '0;
	logic [PIX_W-1:0] diag_pix = '0;
	int               pos_x = 0;
	int               pos_y = 0;

	stim_row_t directed_stim [27] = '{
		'{STIM_PIXEL_KNOWN, REG_PLANE_WIDTH,  16'h0000,  9'sd255,  9'sd255, 1'b1},
		'{STIM_PIXEL_KNOWN, REG_PLANE_WIDTH,  16'h0000, -9'sd255,  9'sd0,   1'b1},
		'{STIM_PIXEL_KNOWN, REG_PLANE_WIDTH,  16'h0000,  9'sd0,    9'sd0,   1'b1},
		'{STIM_WRITE,       REG_PLANE_WIDTH,  16'h0000,  9'sd0,    9'sd0,   1'b0},
		'{STIM_WRITE,       REG_PLANE_HEIGHT, 16'h0000,  9'sd0,    9'sd0,   1'b0},
		'{STIM_PIXEL_KNOWN, REG_PLANE_WIDTH,  16'h0000,  9'sd128,  9'sd128, 1'b1},
		'{STIM_WRITE,       REG_PLANE_WIDTH,  16'h0003,  9'sd0,    9'sd0,   1'b0},
		'{STIM_WRITE,       REG_PLANE_HEIGHT, 16'h0002,  9'sd0,    9'sd0,   1'b0},
		'{STIM_PIXEL_KNOWN, REG_PLANE_WIDTH,  16'h0000,  9'sd10,   9'sd10,  1'b0},
		'{STIM_PIXEL_KNOWN, REG_PLANE_WIDTH,  16'h0000,  9'sd20,   9'sd10,  1'b0},
		'{STIM_PIXEL,       REG_PLANE_WIDTH,  16'h0000,  9'sd30,   9'sd0,   1'b0},
		'{STIM_PIXEL,       REG_PLANE_WIDTH,  16'h0000,  9'sd40,   9'sd0,   1'b0},
		'{STIM_PIXEL,       REG_PLANE_WIDTH,  16'h0000, -9'sd7,    9'sd0,   1'b0},
		'{STIM_PIXEL,       REG_PLANE_WIDTH,  16'h0000,  9'sd255,  9'sd0,   1'b0},
		'{STIM_PIXEL,       REG_PLANE_WIDTH,  16'h0000,  9'sd77,   9'sd0,   1'b0},
		'{STIM_WRITE,       REG_DECODE_MODE,  16'h0001,  9'sd0,    9'sd0,   1'b0},
		'{STIM_WRITE,       REG_PLANE_WIDTH,  16'h0002,  9'sd0,    9'sd0,   1'b0},
		'{STIM_WRITE,       REG_PLANE_HEIGHT, 16'h0002,  9'sd0,    9'sd0,   1'b0},
		'{STIM_PIXEL_KNOWN, REG_PLANE_WIDTH,  16'h0000,  9'sd255,  9'sd255, 1'b0},
		'{STIM_PIXEL,       REG_PLANE_WIDTH,  16'h0000, -9'sd255,  9'sd0,   1'b0},
		'{STIM_PIXEL,       REG_PLANE_WIDTH,  16'h0000,  9'sd255,  9'sd0,   1'b0},
		'{STIM_PIXEL,       REG_PLANE_WIDTH,  16'h0000,  9'sd0,    9'sd0,   1'b0},
		'{STIM_WRITE,       REG_PLANE_WIDTH,  16'hFFFF,  9'sd0,    9'sd0,   1'b0},
		'{STIM_WRITE,       REG_PLANE_HEIGHT, 16'hFFFF,  9'sd0,    9'sd0,   1'b0},
		'{STIM_PIXEL_KNOWN, REG_PLANE_WIDTH,  16'h0000, -9'sd255,  9'sd0,   1'b0},
		'{STIM_PIXEL,       REG_PLANE_WIDTH,  16'h0000,  9'sd255,  9'sd0,   1'b0},
		'{STIM_WRITE,       REG_DECODE_MODE,  16'hFFFE,  9'sd0,    9'sd0,   1'b0}
	};

	med_prediction_residual_codec #(
		.MAX_WIDTH(PLANE_MAX_W)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample_value(sample_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_value(result_value),
		.end_of_plane(end_of_plane)
	);

	always #6 clk = ~clk;

	function automatic coded_pixel_t code_pixel(input logic signed [VAL_W-1:0] s);
		int w, h, top, left, diag, grad, lo, hi, pred, pix;
		coded_pixel_t r;
		w = (plane_w_cfg == 0) ? 1 : int'(plane_w_cfg);
		if (w > PLANE_MAX_W)
			w = PLANE_MAX_W;
		h = (plane_h_cfg == 0) ? 1 : int'(plane_h_cfg);
		top  = (pos_y != 0) ? int'(prev_row[pos_x]) : 0;
		left = (pos_x != 0) ? int'(left_pix) : 0;
		diag = (pos_x != 0 && pos_y != 0) ? int'(diag_pix) : 0;
		grad = top + left - diag;
		lo   = (top < left) ? top : left;
		hi   = (top < left) ? left : top;
		pred = (grad < lo) ? lo : ((grad > hi) ? hi : grad);
		if (decode_cfg) begin
			pix = int'(s) + pred;
			pix = (pix < 0) ? 0 : ((pix > 255) ? 255 : pix);
			r.value = VAL_W'(pix);
		end else begin
			pix = (int'(s) < 0) ? 0 : int'(s);
			r.value = VAL_W'(pix - pred);
		end
		diag_pix = PIX_W'(top);
		left_pix = PIX_W'(pix);
		prev_row[pos_x] = PIX_W'(pix);
		r.eop = 1'b0;
		pos_x++;
		if (pos_x >= w) begin
			pos_x = 0;
			pos_y++;
			if (pos_y >= h) begin
				pos_y = 0;
				r.eop = 1'b1;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic write_register(input cfg_reg_t idx, input logic [CFG_D_W-1:0] data);
		in_valid <= 1'b0;
		while (coded_q.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		unique case (idx)
			REG_PLANE_WIDTH:  plane_w_cfg = data[PW_W-1:0];
			REG_PLANE_HEIGHT: plane_h_cfg = data[PH_W-1:0];
			REG_DECODE_MODE:  decode_cfg = data[0];
			default: ;
		endcase
		pos_x = 0;
		pos_y = 0;
		left_pix = '0;
		diag_pix = '0;
	endtask

	task automatic push_sample(input logic signed [VAL_W-1:0] s, input bit known,
			input logic signed [VAL_W-1:0] want_value, input logic want_eop);
		coded_pixel_t r;
		cfg_valid <= 1'b0;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		sample_value <= s;
		do
			@(posedge clk);
		while (!in_ready);
		r = code_pixel(s);
		if (known) begin
			r.value = want_value;
			r.eop   = want_eop;
		end
		coded_q.push_back(r);
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		coded_pixel_t want;
		if (arst_n && out_valid && out_ready) begin
			if (coded_q.size() == 0) begin
				report_mismatch("unexpected transfer", int'(result_value), 0);
			end else begin
				want = coded_q.pop_front();
				if (result_value !== want.value)
					report_mismatch("result_value", int'(result_value), int'(want.value));
				if (end_of_plane !== want.eop)
					report_mismatch("end_of_plane", int'(end_of_plane), int'(want.eop));
			end
		end
	end

	initial begin
		#20_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int w, h, n, placed, level, v, sel;
		logic [CFG_D_W-1:0] mode_data;
		arst_n       <= 1'b0;
		cfg_valid    <= 1'b0;
		cfg_index    <= REG_PLANE_WIDTH;
		cfg_data     <= '0;
		in_valid     <= 1'b0;
		sample_value <= '0;
		level = 128;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 33;
		recv_idle_pct = 60;
		foreach (directed_stim[i]) begin
			if (directed_stim[i].kind == STIM_WRITE)
				write_register(directed_stim[i].idx, directed_stim[i].data);
			else
				push_sample(directed_stim[i].sample, directed_stim[i].kind == STIM_PIXEL_KNOWN,
						directed_stim[i].want_value, directed_stim[i].want_eop);
		end

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 33 : ((ph == 1) ? 60 : 0);
			recv_idle_pct = (ph == 0) ? 60 : ((ph == 1) ? 33 : 0);
			if (ph == 2) begin
				// A wide plane over two rows, so the top neighbour is read across many columns.
				write_register(REG_DECODE_MODE, 16'($urandom_range(16'hFFFF)));
				write_register(REG_PLANE_WIDTH, 16'(WIDE_PLANE_W));
				write_register(REG_PLANE_HEIGHT, 16'd2);
				repeat (2 * WIDE_PLANE_W + 3)
					push_sample(9'($urandom_range(255)), 1'b0, '0, 1'b0);
			end
			placed = 0;
			while (placed < RAND_ITEMS_PER_PHASE) begin
				sel = $urandom_range(9);
				w = (sel == 0) ? 0 : ((sel == 1) ? $urandom_range(13, 64) : $urandom_range(1, 12));
				sel = $urandom_range(9);
				h = (sel == 0) ? 0 : ((sel == 1) ? 65535 : $urandom_range(1, 6));
				mode_data = 16'($urandom_range(16'hFFFF));
				write_register(REG_DECODE_MODE, mode_data);
				write_register(REG_PLANE_WIDTH, {3'($urandom_range(7)), 13'(w)});
				write_register(REG_PLANE_HEIGHT, 16'(h));
				if (w == 0)
					w = 1;
				if (h == 0)
					h = 1;
				if (h == 65535)
					n = $urandom_range(1, 3 * w);
				else
					n = w * h * $urandom_range(1, 2) +
							(($urandom_range(3) == 0) ? $urandom_range(1, w) : 0);
				repeat (n) begin
					sel = $urandom_range(7);
					if (mode_data[0]) begin
						if (sel < 4)
							v = $urandom_range(16) - 8;
						else if (sel < 6)
							v = $urandom_range(510) - 255;
						else
							v = (sel == 6) ? 255 : -255;
					end else begin
						level = level + $urandom_range(16) - 8;
						level = (level < 0) ? 0 : ((level > 255) ? 255 : level);
						if (sel == 0)
							v = -$urandom_range(1, 255);
						else if (sel < 4)
							v = $urandom_range(255);
						else
							v = level;
					end
					push_sample(9'(v), 1'b0, '0, 1'b0);
				end
				placed += n;
			end
		end

		in_valid <= 1'b0;
		while (coded_q.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
